### rtl/core/stxf_pkg.sv
// ----------------------------------------------------------------------------
// stxf_pkg
// Shared types and constants of the start/end delimited frame receiver.
// ----------------------------------------------------------------------------
package stxf_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_DATA     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // register map
    localparam logic [APB_AW-1:0] REG_START_DELIM = 3'd0;
    localparam logic [APB_AW-1:0] REG_END_DELIM   = 3'd4;

    localparam logic [BYTE_W-1:0] START_DELIM_RST = 8'h02;
    localparam logic [BYTE_W-1:0] END_DELIM_RST   = 8'h03;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD,
        ST_STATUS
    } t_state;

endpackage

### rtl/core/stxf_if.sv
// ----------------------------------------------------------------------------
// stxf channel interfaces
// Valid/ready channels for received bytes and for deframed results.
// ----------------------------------------------------------------------------
interface stxf_in_if;
    logic                        valid;
    logic                        ready;
    logic [stxf_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface stxf_out_if;
    logic                          valid;
    logic                          ready;
    logic [stxf_pkg::BYTE_W-1:0]   data_byte;
    logic [stxf_pkg::STATUS_W-1:0] frame_status;
    logic                          last;

    modport source (output valid, output data_byte, output frame_status, output last,
                    input ready);
    modport sink   (input valid, input data_byte, input frame_status, input last,
                    output ready);
endinterface

### rtl/core/stxf_buf.sv
// ----------------------------------------------------------------------------
// stxf_buf
// Payload buffer: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module stxf_buf #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_waddr,
    input  logic [stxf_pkg::BYTE_W-1:0]      i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH)-1:0]         i_raddr,
    output logic [stxf_pkg::BYTE_W-1:0]      o_rdata
);

    logic [stxf_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [stxf_pkg::BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/stx_etx_frame_receiver_top.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_receiver_top
// Deframes a byte stream delimited by a start byte and an end byte.
// ----------------------------------------------------------------------------
// Usage:
//   i_rx carries one received byte per request. Outside a frame only the
//   start delimiter matters; other bytes are dropped. Inside a frame payload
//   bytes go to a buffer of BUFFER_BYTES-1 usable entries.
//   o_frame carries results: payload bytes (status 0, last on the final one),
//   an empty-frame marker (status 1) or an overflow error (status 2).
//   The APB port sets the start delimiter (0x0) and end delimiter (0x4).
// Flow:
//   a byte that makes no result keeps i_rx.ready high.
//   Closing a frame of N payload bytes drains the buffer through its single
//   read port, a read state then a load state per byte; output stalls pause it.
//   A status result goes out from its own state. i_rx.ready is low while results go out.
// Reset and stall:
//   synchronous reset returns to waiting for a start delimiter, restores the
//   default delimiters and empties the output register. When o_frame.ready is
//   low the result holds and the drain pauses; no result is lost.
// ----------------------------------------------------------------------------
module stx_etx_frame_receiver_top #(
    parameter int unsigned BUFFER_BYTES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    stxf_in_if.sink                         i_rx,
    stxf_out_if.source                      o_frame,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [stxf_pkg::APB_AW-1:0]     paddr,
    input  logic [stxf_pkg::APB_DW-1:0]     pwdata,
    output logic [stxf_pkg::APB_DW-1:0]     prdata,
    output logic                            pready
);

    localparam int unsigned CW = $clog2(BUFFER_BYTES);
    localparam logic [CW-1:0] FILL_MAX = CW'(BUFFER_BYTES - 1);

    stxf_pkg::t_state r_state, n_state;

    logic [stxf_pkg::BYTE_W-1:0]   r_start_delim, r_end_delim;
    logic                          r_in_frame;
    logic [CW-1:0]                 r_fill_count;
    logic [CW-1:0]                 r_ptr;
    logic [stxf_pkg::STATUS_W-1:0] r_pend_status;

    logic                          r_out_valid;
    logic [stxf_pkg::BYTE_W-1:0]   r_out_data;
    logic [stxf_pkg::STATUS_W-1:0] r_out_status;
    logic                          r_out_last;

    logic                          cfg_wr;
    logic                          rx_acc;
    logic                          is_start, is_end, buf_full;
    logic                          slot_free;
    logic                          ptr_at_end;
    logic                          buf_we, buf_re;
    logic [stxf_pkg::BYTE_W-1:0]   buf_rdata;
    logic                          load_data, load_status;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_delim <= stxf_pkg::START_DELIM_RST;
            r_end_delim   <= stxf_pkg::END_DELIM_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == stxf_pkg::REG_END_DELIM[2]) begin
                r_end_delim <= pwdata[stxf_pkg::BYTE_W-1:0];
            end else begin
                r_start_delim <= pwdata[stxf_pkg::BYTE_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == stxf_pkg::REG_END_DELIM[2]) begin
            prdata = {(stxf_pkg::APB_DW - stxf_pkg::BYTE_W)'(0), r_end_delim};
        end else begin
            prdata = {(stxf_pkg::APB_DW - stxf_pkg::BYTE_W)'(0), r_start_delim};
        end
    end

    // ---------------- byte classification ----------------
    assign rx_acc     = i_rx.valid && i_rx.ready;
    assign is_start   = (i_rx.rx_byte == r_start_delim);
    assign is_end     = (i_rx.rx_byte == r_end_delim);
    assign buf_full   = (r_fill_count == FILL_MAX);
    assign slot_free  = !r_out_valid || o_frame.ready;
    // shared compare: drain pointer against the last filled entry
    assign ptr_at_end = (r_ptr == (r_fill_count - CW'(1)));

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stxf_pkg::ST_IDLE: begin
                if (rx_acc && r_in_frame) begin
                    if (is_end) begin
                        n_state = (r_fill_count == '0) ? stxf_pkg::ST_STATUS
                                                       : stxf_pkg::ST_READ;
                    end else if (buf_full) begin
                        n_state = stxf_pkg::ST_STATUS;
                    end
                end
            end
            stxf_pkg::ST_READ: begin
                n_state = stxf_pkg::ST_LOAD;
            end
            stxf_pkg::ST_LOAD: begin
                if (slot_free) begin
                    n_state = ptr_at_end ? stxf_pkg::ST_IDLE : stxf_pkg::ST_READ;
                end
            end
            stxf_pkg::ST_STATUS: begin
                if (slot_free) begin
                    n_state = stxf_pkg::ST_IDLE;
                end
            end
            default: n_state = stxf_pkg::ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb begin
        i_rx.ready  = 1'b0;
        buf_we      = 1'b0;
        buf_re      = 1'b0;
        load_data   = 1'b0;
        load_status = 1'b0;
        unique case (r_state)
            stxf_pkg::ST_IDLE: begin
                i_rx.ready = 1'b1;
                buf_we     = rx_acc && r_in_frame && !is_end && !buf_full;
            end
            stxf_pkg::ST_READ: begin
                buf_re = 1'b1;
            end
            stxf_pkg::ST_LOAD: begin
                load_data = slot_free;
            end
            stxf_pkg::ST_STATUS: begin
                load_status = slot_free;
            end
            default: begin
                i_rx.ready = 1'b0;
            end
        endcase
    end

    // ---------------- framing state ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= stxf_pkg::ST_IDLE;
            r_in_frame   <= 1'b0;
            r_fill_count <= '0;
            r_ptr        <= '0;
        end else begin
            r_state <= n_state;
            if (rx_acc) begin
                if (!r_in_frame) begin
                    if (is_start) begin
                        r_in_frame   <= 1'b1;
                        r_fill_count <= '0;
                    end
                end else if (is_end) begin
                    r_in_frame <= 1'b0;
                    r_ptr      <= '0;
                end else if (!buf_full) begin
                    r_fill_count <= r_fill_count + CW'(1);
                end else begin
                    // overflow discards the frame
                    r_in_frame   <= 1'b0;
                    r_fill_count <= '0;
                end
            end
            if (load_data) begin
                r_ptr <= r_ptr + CW'(1);
                if (ptr_at_end) begin
                    r_fill_count <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_acc && r_in_frame) begin
            r_pend_status <= is_end ? stxf_pkg::STATUS_EMPTY : stxf_pkg::STATUS_OVERFLOW;
        end
    end

    // ---------------- payload buffer ----------------
    stxf_buf #(
        .DEPTH (BUFFER_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (r_fill_count),
        .i_wdata (i_rx.rx_byte),
        .i_re    (buf_re),
        .i_raddr (r_ptr),
        .o_rdata (buf_rdata)
    );

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_data || load_status) begin
            r_out_valid <= 1'b1;
        end else if (o_frame.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_data) begin
            r_out_data   <= buf_rdata;
            r_out_status <= stxf_pkg::STATUS_DATA;
            r_out_last   <= ptr_at_end;
        end else if (load_status) begin
            r_out_data   <= '0;
            r_out_status <= r_pend_status;
            r_out_last   <= 1'b1;
        end
    end

    assign o_frame.valid        = r_out_valid;
    assign o_frame.data_byte    = r_out_data;
    assign o_frame.frame_status = r_out_status;
    assign o_frame.last         = r_out_last;

    // ---------------- assertions ----------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_count <= FILL_MAX)
        else $error("fill count beyond usable buffer depth");

    a_drain_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stxf_pkg::ST_READ || r_state == stxf_pkg::ST_LOAD)
            |-> (r_ptr < r_fill_count))
        else $error("drain pointer past filled entries");

    a_status_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != stxf_pkg::STATUS_DATA)
            |-> (r_out_data == '0 && r_out_last))
        else $error("status result with payload or without last");

    a_close_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_acc && r_in_frame && is_end) |=> !i_rx.ready)
        else $error("input accepted while a closed frame is pending");

    a_drain_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != stxf_pkg::ST_IDLE) |-> !r_in_frame)
        else $error("results pending while a frame is open");

endmodule

### tb/stxf_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stxf_frame_checker
// Watches the byte, frame and APB channels of the frame receiver, keeps its
// own deframer state, queues the results each accepted byte should cause and
// compares every accepted result against the oldest one waiting.
// ----------------------------------------------------------------------------
module stxf_frame_checker #(
    parameter int unsigned BUFFER_BYTES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_rx_valid,
    input  logic                            i_rx_ready,
    input  logic [stxf_pkg::BYTE_W-1:0]     i_rx_byte,
    input  logic                            i_frame_valid,
    input  logic                            i_frame_ready,
    input  logic [stxf_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic [stxf_pkg::STATUS_W-1:0]   i_frame_status,
    input  logic                            i_last,
    input  logic                            i_psel,
    input  logic                            i_penable,
    input  logic                            i_pwrite,
    input  logic [stxf_pkg::APB_AW-1:0]     i_paddr,
    input  logic [stxf_pkg::APB_DW-1:0]     i_pwdata,
    input  logic [stxf_pkg::APB_DW-1:0]     i_prdata,
    input  logic                            i_pready,
    output int                              o_fail_count,
    output int                              o_pending_count
);
    import stxf_pkg::*;

    localparam int unsigned FILL_W = $clog2(BUFFER_BYTES);

    typedef struct packed {
        logic [BYTE_W-1:0]   data_byte;
        logic [STATUS_W-1:0] frame_status;
        logic                last;
    } frame_result_t;

    frame_result_t     expected_results[$];
    logic [BYTE_W-1:0] start_delim;
    logic [BYTE_W-1:0] end_delim;
    logic              in_frame;
    logic [FILL_W-1:0] fill_count;
    logic [BYTE_W-1:0] payload_buf [BUFFER_BYTES];
    int                mismatches;

    initial begin
        mismatches      = 0;
        o_fail_count    = 0;
        o_pending_count = 0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic push_result(input logic [BYTE_W-1:0] data, input logic [STATUS_W-1:0] status,
                               input logic last);
        frame_result_t r;
        r.data_byte    = data;
        r.frame_status = status;
        r.last         = last;
        expected_results.push_back(r);
    endtask

    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        if (!in_frame) begin
            if (b == start_delim) begin
                in_frame   = 1'b1;
                fill_count = '0;
            end
        end else if (b == end_delim) begin
            // end check wins over start when both delimiters are equal
            in_frame = 1'b0;
            if (fill_count == 0) begin
                push_result('0, STATUS_EMPTY, 1'b1);
            end else begin
                for (int i = 0; i < int'(fill_count); i++)
                    push_result(payload_buf[i], STATUS_DATA, (i + 1 == int'(fill_count)));
            end
            fill_count = '0;
        end else if (fill_count < FILL_W'(BUFFER_BYTES - 1)) begin
            payload_buf[fill_count] = b;
            fill_count = fill_count + 1'b1;
        end else begin
            in_frame   = 1'b0;
            fill_count = '0;
            push_result('0, STATUS_OVERFLOW, 1'b1);
        end
    endtask

    always @(posedge i_clk) begin
        frame_result_t want;
        logic [BYTE_W-1:0] reg_val;
        if (!i_rst_n) begin
            expected_results.delete();
            start_delim = START_DELIM_RST;
            end_delim   = END_DELIM_RST;
            in_frame    = 1'b0;
            fill_count  = '0;
        end else begin
            if (i_frame_valid === 1'b1 && i_frame_ready === 1'b1) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result, data_byte", 32'(i_data_byte), 32'h0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_data_byte !== want.data_byte)
                        report_mismatch("data_byte", 32'(i_data_byte), 32'(want.data_byte));
                    if (i_frame_status !== want.frame_status)
                        report_mismatch("frame_status", 32'(i_frame_status),
                                        32'(want.frame_status));
                    if (i_last !== want.last)
                        report_mismatch("last", 32'(i_last), 32'(want.last));
                end
            end
            if (i_rx_valid === 1'b1 && i_rx_ready === 1'b1)
                deframe_byte(i_rx_byte);
            if (i_psel === 1'b1 && i_penable === 1'b1 && i_pready === 1'b1) begin
                if (i_pwrite) begin
                    case (i_paddr)
                        REG_START_DELIM: start_delim = i_pwdata[BYTE_W-1:0];
                        REG_END_DELIM:   end_delim   = i_pwdata[BYTE_W-1:0];
                        default: ;
                    endcase
                end else if (i_paddr == REG_START_DELIM || i_paddr == REG_END_DELIM) begin
                    reg_val = (i_paddr == REG_START_DELIM) ? start_delim : end_delim;
                    if (i_prdata !== APB_DW'(reg_val))
                        report_mismatch("prdata", i_prdata, 32'(reg_val));
                end
            end
        end
        o_fail_count    <= mismatches;
        o_pending_count <= expected_results.size();
    end

endmodule

### tb/tb_stx_etx_frame_receiver_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stx_etx_frame_receiver_top
// Drives delimited byte streams into the frame receiver under several
// delimiter settings and idle/stall mixes; the checker beside the block
// predicts and compares the results, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_stx_etx_frame_receiver_top;
    import stxf_pkg::*;

    localparam int unsigned BUFFER_BYTES = 16;
    localparam int          CYCLE_LIMIT  = 300000;
    localparam int          SETTLE_CYCLES = 2 * BUFFER_BYTES + 10;
    localparam int          PHASE_ITEMS  = 22;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    int                fail_count;
    int                pending_count;
    int                cycles = 0;
    int                sender_idle_pct = 0;
    int                recv_stall_pct = 0;
    logic [BYTE_W-1:0] cur_start;
    logic [BYTE_W-1:0] cur_end;

    stxf_in_if  rx_if ();
    stxf_out_if frame_if ();

    stx_etx_frame_receiver_top #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_frame (frame_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    stxf_frame_checker #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_rx_valid      (rx_if.valid),
        .i_rx_ready      (rx_if.ready),
        .i_rx_byte       (rx_if.rx_byte),
        .i_frame_valid   (frame_if.valid),
        .i_frame_ready   (frame_if.ready),
        .i_data_byte     (frame_if.data_byte),
        .i_frame_status  (frame_if.frame_status),
        .i_last          (frame_if.last),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_prdata        (prdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) cycles <= cycles + 1;

    initial begin
        while (cycles < CYCLE_LIMIT) @(posedge i_clk);
        $display("[stx_etx_frame_receiver_top] ERROR");
        $finish;
    end

    // result side: random back-pressure
    initial begin
        frame_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            frame_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            rx_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_if.ready) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(input logic [APB_AW-1:0] addr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_count != 0) @(posedge i_clk);
    endtask

    // a closing request may still be draining after the last result showed up
    task automatic wait_block_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (pending_count != 0) begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
        end
    endtask

    task automatic set_delimiters(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
        rx_if.valid <= 1'b0;
        wait_block_idle();
        apb_write(REG_START_DELIM, APB_DW'(s));
        apb_write(REG_END_DELIM, APB_DW'(e));
        apb_read(REG_START_DELIM);
        apb_read(REG_END_DELIM);
        cur_start = s;
        cur_end   = e;
    endtask

    // n_payload of BUFFER_BYTES forces the overflow on the last byte
    task automatic send_frame(input int n_payload, input bit closed, inout int sent);
        logic [BYTE_W-1:0] b;
        send_byte(cur_start);
        sent++;
        for (int i = 0; i < n_payload; i++) begin
            b = BYTE_W'($urandom_range(255));
            while (b == cur_end) b = BYTE_W'($urandom_range(255));
            send_byte(b);
            sent++;
        end
        if (closed) begin
            send_byte(cur_end);
            sent++;
        end
    endtask

    task automatic run_traffic(input int n_items);
        int sent;
        int pick;
        int len;
        bit closed;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_byte(BYTE_W'($urandom_range(255)));
                sent++;
            end else if (pick < 11) begin
                if (pending_count != 0) begin
                    rx_if.valid <= 1'b0;
                    wait_drained();
                end
            end else begin
                pick = $urandom_range(99);
                if (pick < 12)      len = 0;
                else if (pick < 62) len = $urandom_range(4, 1);
                else if (pick < 80) len = $urandom_range(BUFFER_BYTES - 2, 5);
                else if (pick < 90) len = BUFFER_BYTES - 1;
                else                len = BUFFER_BYTES;
                closed = (len < BUFFER_BYTES) && ($urandom_range(99) >= 8);
                send_frame(len, closed, sent);
            end
        end
    endtask

    initial begin
        logic [BYTE_W-1:0] s;
        logic [BYTE_W-1:0] e;
        i_rst_n       <= 1'b0;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        cur_start      = START_DELIM_RST;
        cur_end        = END_DELIM_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset delimiters, no idling: stray bytes, empty frame, start
        // delimiter as payload, payload extremes, single byte
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(END_DELIM_RST);
        send_byte(START_DELIM_RST);
        send_byte(END_DELIM_RST);
        send_byte(START_DELIM_RST);
        send_byte(START_DELIM_RST);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(END_DELIM_RST);
        send_byte(START_DELIM_RST);
        send_byte(8'h55);
        send_byte(END_DELIM_RST);
        begin
            int n;
            n = 0;
            // full buffer then end, then full buffer then one more byte
            send_frame(BUFFER_BYTES - 1, 1'b1, n);
            send_frame(BUFFER_BYTES, 1'b0, n);
        end
        run_traffic(PHASE_ITEMS);

        set_delimiters(8'h00, 8'hFF);
        sender_idle_pct = 57;
        recv_stall_pct  = 0;
        run_traffic(PHASE_ITEMS);

        set_delimiters(8'hFF, 8'h00);
        sender_idle_pct = 0;
        recv_stall_pct  = 57;
        run_traffic(PHASE_ITEMS);

        // equal delimiters: opens outside a frame, closes inside
        s = BYTE_W'($urandom_range(255));
        set_delimiters(s, s);
        sender_idle_pct = 37;
        recv_stall_pct  = 37;
        run_traffic(PHASE_ITEMS);

        s = BYTE_W'($urandom_range(255));
        e = BYTE_W'($urandom_range(255));
        while (e == s) e = BYTE_W'($urandom_range(255));
        set_delimiters(s, e);
        sender_idle_pct = 37;
        recv_stall_pct  = 37;
        run_traffic(PHASE_ITEMS / 2);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        run_traffic(PHASE_ITEMS / 2);

        rx_if.valid <= 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("[stx_etx_frame_receiver_top] OK");
        end else begin
            $display("[stx_etx_frame_receiver_top] ERROR");
        end
        $finish;
    end

endmodule
